// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is low.
`define LZWE_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("lzwe assertion failed");

// Same, without the reset guard.
`define LZWE_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("lzwe assertion failed");

`endif

// File: hw/rtl/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// lzwe_pkg
// Constants, types and the hash function of the LZW encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

	localparam int CODE_BITS    = 12;
	localparam int DICT_ENTRIES = 4096;
	localparam int BYTE_BITS    = 8;
	localparam int FIRST_FREE   = 256;
	// hash table holds twice as many slots as codes: load stays below one half
	localparam int SLOT_BITS    = CODE_BITS + 1;
	localparam int DICT_W       = CODE_BITS + BYTE_BITS + SLOT_BITS;
	localparam int OUT_W        = ((CODE_BITS + 7) / 8) * 8;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [BYTE_BITS-1:0] byte_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SLOT,
		ST_DICT,
		ST_PUSH
	} lzwe_state_t;

	typedef struct packed {
		logic [1:0] n;
		code_t      code_a;
		logic       last_a;
		code_t      code_b;
		logic       last_b;
	} lzwe_push_t;

	function automatic slot_t slot_hash(code_t prefix, byte_t b);
		slot_t p;
		slot_t s;
		p = slot_t'(prefix);
		s = slot_t'({b, {(SLOT_BITS - BYTE_BITS){1'b0}}});
		return p ^ s;
	endfunction

endpackage

// File: hw/rtl/lzwe_ram.sv
// ----------------------------------------------------------------------------
// lzwe_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwe_ram #(
	parameter int AW = 12,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: hw/rtl/lzwe_out_q.sv
// ----------------------------------------------------------------------------
// lzwe_out_q
// Two-entry output queue; takes up to two codes per cycle.
// ----------------------------------------------------------------------------
module lzwe_out_q (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lzwe_pkg::lzwe_push_t   push,
	output logic [1:0]             free,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [lzwe_pkg::OUT_W-1:0] m_tdata,
	output logic                   m_tlast
);

	lzwe_pkg::code_t code_q [2];
	logic            last_q [2];
	logic [1:0]      cnt_q;

	lzwe_pkg::code_t code_d [2];
	logic            last_d [2];
	logic [1:0]      cnt_d;
	logic            pop;

	assign pop      = m_tvalid && m_tready;
	assign free     = 2'd2 - cnt_q;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = lzwe_pkg::OUT_W'(code_q[0]);
	assign m_tlast  = last_q[0];

	always_comb begin
		code_d = code_q;
		last_d = last_q;
		cnt_d  = cnt_q;
		if (pop) begin
			code_d[0] = code_q[1];
			last_d[0] = last_q[1];
			cnt_d     = cnt_d - 2'd1;
		end
		if (push.n != 2'd0) begin
			code_d[cnt_d[0]] = push.code_a;
			last_d[cnt_d[0]] = push.last_a;
			cnt_d            = cnt_d + 2'd1;
		end
		if (push.n == 2'd2) begin
			code_d[cnt_d[0]] = push.code_b;
			last_d[cnt_d[0]] = push.last_b;
			cnt_d            = cnt_d + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		code_q <= code_d;
		last_q <= last_d;
	end

endmodule

// File: hw/rtl/lzw_encoder_12bit_core.sv
// ----------------------------------------------------------------------------
// lzw_encoder_12bit_core
// LZW encoder: hashed dictionary lookup, 12-bit codes out.
//
//  channel | dir | payload
//  s_*     | in  | tdata[7:0] source byte, tlast final byte
//  m_*     | out | tdata[11:0] code (upper bits zero), tlast final code
//
// The first byte of a stream goes from ST_IDLE straight to ST_PUSH. Otherwise
// each hash probe reads the slot RAM, then the code RAM (both with registered
// read data); the search ends in ST_SLOT on an empty slot and in ST_DICT on a
// hit or a stale entry, and a collision steps on to the next slot.
// Reset clears control state only; RAM contents are validated per probe by
// the code range and the back-pointer to the slot, so no clearing pass.
// An output queue without room for the item's codes stalls it in ST_PUSH.
// ----------------------------------------------------------------------------
module lzw_encoder_12bit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] out_code, [15:12] zero
	output logic        m_tlast
);

	localparam lzwe_pkg::code_t FIRST_CODE = lzwe_pkg::code_t'(lzwe_pkg::FIRST_FREE);
	localparam lzwe_pkg::code_t LAST_CODE  = lzwe_pkg::code_t'(lzwe_pkg::DICT_ENTRIES - 1);

	lzwe_pkg::lzwe_state_t state_q, state_d;
	lzwe_pkg::byte_t       byte_q, byte_d;
	logic                  last_q, last_d;
	lzwe_pkg::code_t       pend_q, pend_d;
	logic                  pvalid_q, pvalid_d;
	lzwe_pkg::code_t       nfree_q, nfree_d;
	lzwe_pkg::slot_t       probe_q, probe_d;
	lzwe_pkg::code_t       code_q, code_d;
	lzwe_pkg::lzwe_push_t  emit_q, emit_d;

	logic                          slot_we;
	lzwe_pkg::slot_t               slot_addr;
	lzwe_pkg::code_t               slot_rdata;
	logic                          dict_we;
	lzwe_pkg::code_t               dict_addr;
	logic [lzwe_pkg::DICT_W-1:0]   dict_wdata;
	logic [lzwe_pkg::DICT_W-1:0]   dict_rdata;

	lzwe_pkg::lzwe_push_t push;
	logic [1:0]           free;

	lzwe_pkg::code_t d_prefix;
	lzwe_pkg::byte_t d_byte;
	lzwe_pkg::slot_t d_slot;
	logic            in_range;
	logic            fin_go;
	logic            fin_miss;
	lzwe_pkg::code_t fin_newp;
	logic            cur_last;
	logic            ins;

	assign d_prefix = dict_rdata[lzwe_pkg::CODE_BITS-1:0];
	assign d_byte   = dict_rdata[lzwe_pkg::CODE_BITS +: lzwe_pkg::BYTE_BITS];
	assign d_slot   = dict_rdata[lzwe_pkg::CODE_BITS + lzwe_pkg::BYTE_BITS +: lzwe_pkg::SLOT_BITS];
	assign in_range = (slot_rdata >= FIRST_CODE) && (slot_rdata < nfree_q);
	assign cur_last = (state_q == lzwe_pkg::ST_IDLE) ? s_tlast : last_q;
	assign ins      = (nfree_q != LAST_CODE);
	assign s_tready = (state_q == lzwe_pkg::ST_IDLE);

	always_comb begin
		state_d    = state_q;
		byte_d     = byte_q;
		last_d     = last_q;
		pend_d     = pend_q;
		pvalid_d   = pvalid_q;
		nfree_d    = nfree_q;
		probe_d    = probe_q;
		code_d     = code_q;
		emit_d     = emit_q;
		slot_we    = 1'b0;
		slot_addr  = probe_q;
		dict_we    = 1'b0;
		dict_addr  = slot_rdata;
		dict_wdata = {probe_q, byte_q, pend_q};
		fin_go     = 1'b0;
		fin_miss   = 1'b0;
		fin_newp   = pend_q;
		push       = '0;

		unique case (state_q)
			lzwe_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					byte_d = s_tdata;
					last_d = s_tlast;
					if (!pvalid_q) begin
						fin_go   = 1'b1;
						fin_newp = lzwe_pkg::code_t'(s_tdata);
					end else begin
						slot_addr = lzwe_pkg::slot_hash(pend_q, s_tdata);
						probe_d   = slot_addr;
						state_d   = lzwe_pkg::ST_SLOT;
					end
				end
			end
			lzwe_pkg::ST_SLOT: begin
				if (in_range) begin
					code_d  = slot_rdata;
					state_d = lzwe_pkg::ST_DICT;
				end else begin
					fin_miss = 1'b1;
				end
			end
			lzwe_pkg::ST_DICT: begin
				if (d_slot != probe_q) begin
					fin_miss = 1'b1;
				end else if (d_prefix == pend_q && d_byte == byte_q) begin
					fin_go   = 1'b1;
					fin_newp = code_q;
				end else begin
					// collision: step to the next slot
					probe_d   = probe_q + lzwe_pkg::slot_t'(1);
					slot_addr = probe_d;
					state_d   = lzwe_pkg::ST_SLOT;
				end
			end
			lzwe_pkg::ST_PUSH: begin
				if (free >= emit_q.n) begin
					push    = emit_q;
					state_d = lzwe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lzwe_pkg::ST_IDLE;
			end
		endcase

		if (fin_miss) begin
			// insert at the empty slot; the entry that fills the table is dropped
			fin_go    = 1'b1;
			fin_newp  = lzwe_pkg::code_t'(byte_q);
			slot_we   = ins;
			slot_addr = probe_q;
			dict_we   = ins;
			dict_addr = nfree_q;
			nfree_d   = ins ? nfree_q + lzwe_pkg::code_t'(1) : FIRST_CODE;
		end

		if (fin_go) begin
			state_d  = lzwe_pkg::ST_PUSH;
			pvalid_d = 1'b1;
			pend_d   = fin_newp;
			emit_d   = '0;
			if (fin_miss) begin
				emit_d.code_a = pend_q;
				emit_d.last_a = 1'b0;
				emit_d.code_b = fin_newp;
				emit_d.last_b = 1'b1;
				emit_d.n      = cur_last ? 2'd2 : 2'd1;
			end else if (cur_last) begin
				emit_d.code_a = fin_newp;
				emit_d.last_a = 1'b1;
				emit_d.n      = 2'd1;
			end
			if (cur_last) begin
				pvalid_d = 1'b0;
				pend_d   = '0;
				nfree_d  = FIRST_CODE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lzwe_pkg::ST_IDLE;
			pvalid_q <= 1'b0;
			pend_q   <= '0;
			nfree_q  <= FIRST_CODE;
			emit_q   <= '0;
		end else begin
			state_q  <= state_d;
			pvalid_q <= pvalid_d;
			pend_q   <= pend_d;
			nfree_q  <= nfree_d;
			emit_q   <= emit_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q  <= byte_d;
		last_q  <= last_d;
		probe_q <= probe_d;
		code_q  <= code_d;
	end

	lzwe_ram #(
		.AW(lzwe_pkg::SLOT_BITS),
		.DW(lzwe_pkg::CODE_BITS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.addr (slot_addr),
		.wdata(nfree_q),
		.rdata(slot_rdata)
	);

	lzwe_ram #(
		.AW(lzwe_pkg::CODE_BITS),
		.DW(lzwe_pkg::DICT_W)
	) u_dict_ram (
		.clk  (clk),
		.we   (dict_we),
		.addr (dict_addr),
		.wdata(dict_wdata),
		.rdata(dict_rdata)
	);

	lzwe_out_q u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.free    (free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// File: hw/rtl/lzwe_checker.sv
// ----------------------------------------------------------------------------
// lzwe_checker
// Port-level checks of the LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzwe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// hold a stalled code
	`LZWE_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// an accepted byte keeps the input closed in the following cycle
	`LZWE_ASSERT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready |=> !s_tready)
	// pad bits above the code stay zero
	`LZWE_ASSERT(a_code_pad, clk, arst_n, m_tvalid |-> m_tdata[15:12] == 4'd0)
	// no output while reset is asserted
	`LZWE_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid)

endmodule

bind lzw_encoder_12bit_core lzwe_checker u_lzwe_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lzw_encoder_12bit_core: drives byte streams, runs an
// LZW dictionary predictor alongside, and compares every emitted code.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	typedef struct {
		logic [11:0] code;
		logic        last;
	} code_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;

	byte_item_t pending_bytes[$];
	code_item_t expected_codes[$];
	int         fail_count;
	bit         idle_enable;
	int         long_hold;
	bit         in_fire;

	// predictor state
	logic [11:0] pm_prefix[lzwe_pkg::DICT_ENTRIES];
	logic [7:0]  pm_byte[lzwe_pkg::DICT_ENTRIES];
	int          pm_next_free;
	logic [11:0] pm_pending;
	bit          pm_valid;

	lzw_encoder_12bit_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic push_code(input logic [11:0] code, input logic last);
		code_item_t c;
		c.code = code;
		c.last = last;
		expected_codes.push_back(c);
	endtask

	task automatic predict_codes(input byte_item_t it);
		int  i;
		int  found;
		found = -1;
		if (!pm_valid) begin
			pm_pending = {4'b0, it.data};
			pm_valid = 1;
		end else begin
			for (i = lzwe_pkg::FIRST_FREE; i < pm_next_free && found < 0; i++)
				if (pm_prefix[i] == pm_pending && pm_byte[i] == it.data)
					found = i;
			if (found >= 0) begin
				pm_pending = found[11:0];
			end else begin
				push_code(pm_pending, 1'b0);
				pm_prefix[pm_next_free] = pm_pending;
				pm_byte[pm_next_free] = it.data;
				pm_next_free++;
				if (pm_next_free >= lzwe_pkg::DICT_ENTRIES)
					pm_next_free = lzwe_pkg::FIRST_FREE;
				pm_pending = {4'b0, it.data};
			end
		end
		if (it.last) begin
			push_code(pm_pending, 1'b1);
			pm_valid = 0;
			pm_pending = '0;
			pm_next_free = lzwe_pkg::FIRST_FREE;
		end
	endtask

	task automatic add_byte(input logic [7:0] d, input logic l);
		byte_item_t it;
		it.data = d;
		it.last = l;
		pending_bytes.push_back(it);
	endtask

	// input handshakes seen at the rising edge
	always @(posedge clk) begin
		in_fire <= arst_n && s_tvalid && s_tready;
	end

	// driver
	int src_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			src_gap = 0;
		end else begin
			if (in_fire) begin
				predict_codes(pending_bytes.pop_front());
				if (idle_enable && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 16);
			end
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_bytes[0].data;
				s_tlast <= pending_bytes[0].last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink stalls
	int sink_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
		end else if (long_hold > 0) begin
			long_hold--;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 7) == 0) begin
			sink_gap = $urandom_range(1, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		code_item_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_codes.size() == 0) begin
				report_mismatch($sformatf("unexpected code %0h", m_tdata[11:0]));
			end else begin
				e = expected_codes.pop_front();
				if (m_tdata[11:0] !== e.code)
					report_mismatch($sformatf("code %0h, want %0h", m_tdata[11:0], e.code));
				if (m_tdata[15:12] !== 4'b0)
					report_mismatch("upper code bits not zero");
				if (m_tlast !== e.last)
					report_mismatch($sformatf("last %b, want %b", m_tlast, e.last));
			end
		end
	end

	initial begin
		#20000000;
		$display("lzw_encoder_12bit_core test failed");
		$finish;
	end

	initial begin
		int i;
		int n;
		int len;
		int alpha;
		clk = 0;
		arst_n = 0;
		fail_count = 0;
		idle_enable = 1;
		long_hold = 0;
		pm_next_free = lzwe_pkg::FIRST_FREE;
		pm_valid = 0;
		pm_pending = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: single-byte stream, extremes, repeats, alternating bits
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b1);
		for (i = 0; i < 8; i++) add_byte(8'h55, 1'b0);
		add_byte(8'hAA, 1'b0); add_byte(8'hAA, 1'b0); add_byte(8'h55, 1'b1);

		// long hold-off on the output while bytes keep coming
		long_hold = 300;
		for (i = 0; i < 60; i++) add_byte(8'($urandom_range(0, 3)), i == 59);

		// random streams, mostly small alphabets so the dictionary gets hits
		n = 0;
		while (n < 420) begin
			len = $urandom_range(1, 60);
			alpha = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 7);
			for (i = 0; i < len; i++)
				add_byte(8'($urandom_range(0, alpha)), i == len - 1);
			n += len;
		end

		// no idling in the last part of the run
		wait (pending_bytes.size() < 100);
		idle_enable = 0;

		while (pending_bytes.size() > 0 || expected_codes.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("lzw_encoder_12bit_core test passed");
		else
			$display("lzw_encoder_12bit_core test failed");
		$finish;
	end
endmodule
